// ===== design/bmftl_pkg.sv =====
// shared types and constants of the block-mapping flash translation layer
`default_nettype none

package bmftl_pkg;

    // fixed field widths
    localparam int SECTOR_W   = 6;
    localparam int CMD_W      = 3;
    localparam int PAGE_OUT_W = 7;
    localparam int BLK_OUT_W  = 5;

    // default geometry
    localparam int PAGES_PER_BLK_DEF  = 4;
    localparam int LOGICAL_BLOCKS_DEF = 16;

    // flash command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_READ     = 3'd0,
        CMD_PROGRAM  = 3'd1,
        CMD_ERASE    = 3'd2,
        CMD_COPY     = 3'd3,
        CMD_UNMAPPED = 3'd4,
        CMD_NOFREE   = 3'd5
    } t_cmd;

    // which addresses go out with a command
    typedef enum logic [2:0] {
        SEL_NONE      = 3'd0,
        SEL_HOME      = 3'd1,
        SEL_NEW       = 3'd2,
        SEL_COPY      = 3'd3,
        SEL_ERASE_NEW = 3'd4,
        SEL_ERASE_OLD = 3'd5
    } t_sel;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic look;
        logic upd_assign;
        logic upd_program;
        logic upd_merge;
        logic scan_step;
        logic emit;
        t_cmd code;
        t_sel sel;
        logic last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic wr;
        logic out_range;
        logic mapped;
        logic full;
        logic hit;
        logic copy_hit;
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== design/bmftl_if.sv =====
// request and flash command channel interfaces
`default_nettype none

interface bmftl_req_if;
    import bmftl_pkg::*;

    logic                valid;
    logic                ready;
    logic                action;
    logic [SECTOR_W-1:0] sector_number;

    modport source (output valid, output action, output sector_number, input ready);
    modport sink   (input valid, input action, input sector_number, output ready);
endinterface

interface bmftl_cmd_if;
    import bmftl_pkg::*;

    logic                  valid;
    logic                  ready;
    t_cmd                  command;
    logic [PAGE_OUT_W-1:0] page_address;
    logic [PAGE_OUT_W-1:0] source_page;
    logic [BLK_OUT_W-1:0]  block_number;
    logic                  last;

    modport source (output valid, output command, output page_address, output source_page,
                    output block_number, output last, input ready);
    modport sink   (input valid, input command, input page_address, input source_page,
                    input block_number, input last, output ready);
endinterface

`default_nettype wire

// ===== design/block_mapping_ftl.sv =====
// Block-mapping flash translation layer. Each read or write request for a logical
// sector becomes one to PAGES_PER_BLK+2 flash commands (read page, program page,
// erase block, copy page, or an error code), the final one flagged by last. One
// request is handled at a time: a request is taken in the idle cycle, the block
// map is read in the next cycle and the written-page row of the physical block in
// the one after, and a request that yields a single command then emits it. A
// merge (write to an already written page) then emits the erase of the spare
// block, scans the PAGES_PER_BLK offsets at one offset per cycle, unless a copy
// waits on a stalled command channel, for pages to copy, and emits the erase of
// the old block and the program. A stall of the command channel holds each
// command until the output slot is free. Written-page state is cleared at reset
// by per-block valid flags, so the block is ready straight out of reset.
`default_nettype none

module block_mapping_ftl #(
    parameter int PAGES_PER_BLK  = bmftl_pkg::PAGES_PER_BLK_DEF,
    parameter int LOGICAL_BLOCKS = bmftl_pkg::LOGICAL_BLOCKS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bmftl_req_if.sink   i_req,
    bmftl_cmd_if.source o_cmd
);
    import bmftl_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       req_ready;

    // sequencing
    bmftl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    assign i_req.ready = req_ready;

    // map, page state and command output
    bmftl_dp #(
        .PAGES_PER_BLK  (PAGES_PER_BLK),
        .LOGICAL_BLOCKS (LOGICAL_BLOCKS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_action       (i_req.action),
        .i_sector       (i_req.sector_number),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_out_ready    (o_cmd.ready),
        .o_out_valid    (o_cmd.valid),
        .o_command      (o_cmd.command),
        .o_page_address (o_cmd.page_address),
        .o_source_page  (o_cmd.source_page),
        .o_block_number (o_cmd.block_number),
        .o_last         (o_cmd.last)
    );

endmodule

`default_nettype wire

// ===== design/bmftl_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module bmftl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/bmftl_ctrl.sv =====
// controller state machine: lookup, decision and command sequencing
`default_nettype none

module bmftl_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_req_valid,
    output logic                       o_req_ready,
    input  wire bmftl_pkg::t_dp_status i_status,
    output bmftl_pkg::t_dp_cmd         o_cmd
);
    import bmftl_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_LOOK      = 8'b0000_0010,
        S_DECIDE    = 8'b0000_0100,
        S_ONE       = 8'b0000_1000,
        S_ERASE_NEW = 8'b0001_0000,
        S_COPY      = 8'b0010_0000,
        S_ERASE_OLD = 8'b0100_0000,
        S_PROG_NEW  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    t_cmd   r_one_code, n_one_code;
    t_sel   r_one_sel, n_one_sel;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // single command held for emission
    always_ff @(posedge i_clk) begin
        r_one_code <= n_one_code;
        r_one_sel  <= n_one_sel;
    end

    // next state and commands to the datapath
    always_comb begin
        n_state            = r_state;
        n_one_code         = r_one_code;
        n_one_sel          = r_one_sel;
        o_req_ready        = (r_state == S_IDLE) && i_rst_n;
        o_cmd.load         = 1'b0;
        o_cmd.look         = 1'b0;
        o_cmd.upd_assign   = 1'b0;
        o_cmd.upd_program  = 1'b0;
        o_cmd.upd_merge    = 1'b0;
        o_cmd.scan_step    = 1'b0;
        o_cmd.emit         = 1'b0;
        o_cmd.code         = CMD_READ;
        o_cmd.sel          = SEL_NONE;
        o_cmd.last         = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_ONE;
                if (i_status.out_range) begin
                    n_one_code = i_status.wr ? CMD_NOFREE : CMD_UNMAPPED;
                    n_one_sel  = SEL_NONE;
                end else if (!i_status.wr) begin
                    n_one_code = i_status.mapped ? CMD_READ : CMD_UNMAPPED;
                    n_one_sel  = i_status.mapped ? SEL_HOME : SEL_NONE;
                end else if (!i_status.mapped) begin
                    if (i_status.full) begin
                        n_one_code = CMD_NOFREE;
                        n_one_sel  = SEL_NONE;
                    end else begin
                        o_cmd.upd_assign = 1'b1;
                        n_one_code       = CMD_PROGRAM;
                        n_one_sel        = SEL_HOME;
                    end
                end else if (!i_status.hit) begin
                    o_cmd.upd_program = 1'b1;
                    n_one_code        = CMD_PROGRAM;
                    n_one_sel         = SEL_HOME;
                end else begin
                    o_cmd.upd_merge = 1'b1;
                    n_state         = S_ERASE_NEW;
                end
            end
            S_ONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = r_one_code;
                    o_cmd.sel  = r_one_sel;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_ERASE_NEW: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = CMD_ERASE;
                    o_cmd.sel  = SEL_ERASE_NEW;
                    n_state    = S_COPY;
                end
            end
            S_COPY: begin
                // one offset per cycle unless a copy waits for a free output slot, copy only the other written pages
                if (!i_status.copy_hit || i_status.out_free) begin
                    o_cmd.scan_step = 1'b1;
                    o_cmd.emit      = i_status.copy_hit;
                    o_cmd.code      = CMD_COPY;
                    o_cmd.sel       = SEL_COPY;
                    if (i_status.scan_last) begin
                        n_state = S_ERASE_OLD;
                    end
                end
            end
            S_ERASE_OLD: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = CMD_ERASE;
                    o_cmd.sel  = SEL_ERASE_OLD;
                    n_state    = S_PROG_NEW;
                end
            end
            S_PROG_NEW: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = CMD_PROGRAM;
                    o_cmd.sel  = SEL_NEW;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // a command is only pushed into a free output slot
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("command emitted into an occupied output slot");

    // the final command of a request returns the controller to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == S_IDLE))
        else $error("controller not idle after last command");

    // a new request is never taken while a merge is in flight
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.upd_merge |=> !o_req_ready)
        else $error("request accepted during merge");

endmodule

`default_nettype wire

// ===== design/bmftl_dp.sv =====
// datapath: block map, written-page rows, block allocation and output register
`default_nettype none

module bmftl_dp #(
    parameter int PAGES_PER_BLK  = bmftl_pkg::PAGES_PER_BLK_DEF,
    parameter int LOGICAL_BLOCKS = bmftl_pkg::LOGICAL_BLOCKS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_action,
    input  wire logic [bmftl_pkg::SECTOR_W-1:0]       i_sector,
    input  wire bmftl_pkg::t_dp_cmd                   i_cmd,
    output bmftl_pkg::t_dp_status                     o_status,
    input  wire logic                                 i_out_ready,
    output logic                                      o_out_valid,
    output bmftl_pkg::t_cmd                           o_command,
    output logic      [bmftl_pkg::PAGE_OUT_W-1:0]     o_page_address,
    output logic      [bmftl_pkg::PAGE_OUT_W-1:0]     o_source_page,
    output logic      [bmftl_pkg::BLK_OUT_W-1:0]      o_block_number,
    output logic                                      o_last
);
    import bmftl_pkg::*;

    // geometry reachable from a six-bit sector number
    localparam int MAX_LBN     = (2**SECTOR_W - 1) / PAGES_PER_BLK;
    localparam int MAP_DEPTH   = (LOGICAL_BLOCKS < MAX_LBN + 1) ? LOGICAL_BLOCKS : MAX_LBN + 1;
    localparam int LBN_W       = $clog2(MAX_LBN + 1);
    localparam int MAP_AW      = $clog2(MAP_DEPTH);
    localparam int PHYS_BLOCKS = MAP_DEPTH + 1;
    localparam int BLK_W       = $clog2(PHYS_BLOCKS);
    localparam int OFF_W       = $clog2(PAGES_PER_BLK);
    localparam int PAGE_W      = $clog2(PHYS_BLOCKS * PAGES_PER_BLK);
    // sector / pages-per-block by reciprocal, exact for six-bit sectors
    localparam int RECIP_SH    = 12;
    localparam int RECIP       = (2**RECIP_SH + PAGES_PER_BLK - 1) / PAGES_PER_BLK;
    localparam int PROD_W      = SECTOR_W + RECIP_SH + 1;

    logic                     r_act;
    logic [SECTOR_W-1:0]      r_sec;
    logic [LBN_W-1:0]         r_lbn;
    logic [OFF_W-1:0]         r_off;
    logic [BLK_W-1:0]         r_pbn;
    logic [BLK_W-1:0]         r_nb;
    logic [BLK_W-1:0]         r_spare;
    logic [BLK_W-1:0]         r_next;
    logic [PAGES_PER_BLK-1:0] r_row;
    logic [OFF_W-1:0]         r_scan;
    logic                     r_map_valid [MAP_DEPTH];
    logic                     r_row_valid [PHYS_BLOCKS];

    logic                     r_out_valid;
    t_cmd                     r_command;
    logic [PAGE_OUT_W-1:0]    r_page;
    logic [PAGE_OUT_W-1:0]    r_src;
    logic [BLK_OUT_W-1:0]     r_blk;
    logic                     r_last;

    logic [PROD_W-1:0]        lbn_prod;
    logic [LBN_W-1:0]         lbn_in;
    logic [BLK_W-1:0]         next_blk;
    logic [BLK_W-1:0]         map_rdata;
    logic                     map_we;
    logic [BLK_W-1:0]         map_wdata;
    logic [PAGES_PER_BLK-1:0] row_rdata;
    logic [PAGES_PER_BLK-1:0] eff_row;
    logic [PAGES_PER_BLK-1:0] row_bit;
    logic                     row_we;
    logic [BLK_W-1:0]         row_waddr;
    logic [PAGES_PER_BLK-1:0] row_wdata;
    logic [PAGE_W-1:0]        page_home;
    logic [PAGE_W-1:0]        page_new;
    logic [PAGE_W-1:0]        page_dst;
    logic [PAGE_W-1:0]        page_src;
    logic                     out_free;

    // split sector into logical block at accept time
    assign lbn_prod = PROD_W'(i_sector) * PROD_W'(RECIP);
    assign lbn_in   = LBN_W'(lbn_prod >> RECIP_SH);
    assign next_blk = r_next + BLK_W'(1);
    assign row_bit  = {{(PAGES_PER_BLK-1){1'b0}}, 1'b1} << r_off;
    assign eff_row  = r_row_valid[r_pbn] ? row_rdata : '0;

    // request fields and lookup results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_sec <= i_sector;
            r_lbn <= lbn_in;
        end
        if (i_cmd.look) begin
            r_pbn <= map_rdata;
            r_off <= OFF_W'(r_sec - SECTOR_W'(SECTOR_W'(r_lbn) * SECTOR_W'(PAGES_PER_BLK)));
        end
        if (i_cmd.upd_assign) begin
            r_pbn <= next_blk;
        end
        if (i_cmd.upd_merge) begin
            r_nb   <= r_spare;
            r_row  <= eff_row;
            r_scan <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan <= r_scan + OFF_W'(1);
        end
    end

    // allocation state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spare <= '0;
            r_next  <= '0;
            for (int i = 0; i < MAP_DEPTH; i++) begin
                r_map_valid[i] <= 1'b0;
            end
            for (int i = 0; i < PHYS_BLOCKS; i++) begin
                r_row_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cmd.upd_assign) begin
                r_next                        <= next_blk;
                r_map_valid[r_lbn[MAP_AW-1:0]] <= 1'b1;
                r_row_valid[next_blk]         <= 1'b1;
            end
            if (i_cmd.upd_program) begin
                r_row_valid[r_pbn] <= 1'b1;
            end
            if (i_cmd.upd_merge) begin
                r_spare              <= r_pbn;
                r_row_valid[r_spare] <= 1'b1;
                r_row_valid[r_pbn]   <= 1'b0;
            end
        end
    end

    // block map write
    assign map_we    = i_cmd.upd_assign || i_cmd.upd_merge;
    assign map_wdata = i_cmd.upd_assign ? next_blk : r_spare;

    bmftl_ram #(
        .WIDTH (BLK_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (r_lbn[MAP_AW-1:0]),
        .i_wdata (map_wdata),
        .i_raddr (lbn_in[MAP_AW-1:0]),
        .o_rdata (map_rdata)
    );

    // written-page row write
    always_comb begin
        row_we    = i_cmd.upd_assign || i_cmd.upd_program || i_cmd.upd_merge;
        row_waddr = r_pbn;
        row_wdata = eff_row | row_bit;
        if (i_cmd.upd_assign) begin
            row_waddr = next_blk;
            row_wdata = row_bit;
        end else if (i_cmd.upd_merge) begin
            row_waddr = r_spare;
            row_wdata = eff_row;
        end
    end

    bmftl_ram #(
        .WIDTH (PAGES_PER_BLK),
        .DEPTH (PHYS_BLOCKS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (map_rdata),
        .o_rdata (row_rdata)
    );

    // physical page addresses
    assign page_home = PAGE_W'(r_pbn) * PAGE_W'(PAGES_PER_BLK) + PAGE_W'(r_off);
    assign page_new  = PAGE_W'(r_nb) * PAGE_W'(PAGES_PER_BLK) + PAGE_W'(r_off);
    assign page_dst  = PAGE_W'(r_nb) * PAGE_W'(PAGES_PER_BLK) + PAGE_W'(r_scan);
    assign page_src  = PAGE_W'(r_pbn) * PAGE_W'(PAGES_PER_BLK) + PAGE_W'(r_scan);

    // output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_command <= i_cmd.code;
            r_last    <= i_cmd.last;
            case (i_cmd.sel)
                SEL_HOME: begin
                    r_page <= PAGE_OUT_W'(page_home);
                    r_src  <= '0;
                    r_blk  <= '0;
                end
                SEL_NEW: begin
                    r_page <= PAGE_OUT_W'(page_new);
                    r_src  <= '0;
                    r_blk  <= '0;
                end
                SEL_COPY: begin
                    r_page <= PAGE_OUT_W'(page_dst);
                    r_src  <= PAGE_OUT_W'(page_src);
                    r_blk  <= '0;
                end
                SEL_ERASE_NEW: begin
                    r_page <= '0;
                    r_src  <= '0;
                    r_blk  <= BLK_OUT_W'(r_nb);
                end
                SEL_ERASE_OLD: begin
                    r_page <= '0;
                    r_src  <= '0;
                    r_blk  <= BLK_OUT_W'(r_pbn);
                end
                default: begin
                    r_page <= '0;
                    r_src  <= '0;
                    r_blk  <= '0;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_command      = r_command;
    assign o_page_address = r_page;
    assign o_source_page  = r_src;
    assign o_block_number = r_blk;
    assign o_last         = r_last;

    // status to the controller
    assign o_status.wr        = r_act;
    assign o_status.out_range = (32'(r_lbn) >= 32'(LOGICAL_BLOCKS));
    assign o_status.mapped    = r_map_valid[r_lbn[MAP_AW-1:0]];
    assign o_status.full      = (32'(r_next) >= 32'(LOGICAL_BLOCKS));
    assign o_status.hit       = eff_row[r_off];
    assign o_status.copy_hit  = r_row[r_scan] && (r_scan != r_off);
    assign o_status.scan_last = (32'(r_scan) == 32'(PAGES_PER_BLK - 1));
    assign o_status.out_free  = out_free;

    // the spare block is never the home of a mapped logical block
    a_spare_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd_merge |-> (r_spare != r_pbn))
        else $error("merge with spare equal to home block");

    // the old home, now spare, reads as erased after a merge
    a_spare_erased: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd_merge |=> !r_row_valid[r_spare])
        else $error("new spare block not erased");

    // allocation never runs past the map
    a_next_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd_assign |-> (32'(r_next) < 32'(MAP_DEPTH)))
        else $error("block allocation past map depth");

endmodule

`default_nettype wire
